@@ hdl/chwpi_pkg.sv @@
// Shared types and constants for the cascaded heading and wheel PI controller.
`timescale 1ns / 1ps
`default_nettype none

package chwpi_pkg;

	// Sequencer states of the shared multiplier datapath
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ANG_MUL,
		ST_ANG_ADD,
		ST_HERR_MUL,
		ST_HSUM,
		ST_HKI,
		ST_TGT,
		ST_WERR,
		ST_WI_MUL,
		ST_WSUM,
		ST_WKI,
		ST_WCMD,
		ST_DONE
	} state_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_KP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_KI   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_KP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_KI    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_INC   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_LIMIT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_THR = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS  = 3'd7;

	localparam int CFG_DATA_W = 31;

	// Register reset values
	localparam logic [15:0] WHEEL_KP_RST   = 16'd6912;
	localparam logic [15:0] WHEEL_KI_RST   = 16'd6554;
	localparam logic [15:0] HEAD_KP_RST    = 16'd4063;
	localparam logic [15:0] HEAD_KI_RST    = 16'd66;
	localparam logic [15:0] RAMP_INC_RST   = 16'd13;
	localparam logic [15:0] RAMP_LIMIT_RST = 16'd15360;

	// Time steps in Q16 and integral clamp (50.0 in Q16)
	localparam logic signed [17:0] DT_Q16  = 18'sd131;
	localparam logic signed [17:0] DT1_Q16 = 18'sd66;
	localparam int SUM_CLAMP = 3276800;

	// Shared multiplier widths
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 18;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

endpackage

`default_nettype wire

@@ hdl/cascaded_heading_wheel_pi_control_top.sv @@
// Cascaded heading and wheel speed PI controller for a two-wheel drive.
//
// Usage: one input transaction per 1 kHz control tick carries both encoder
// counts, a gyro Z sample, drive_enable and restart. Each tick returns exactly
// one output transaction with the two saturated motor commands and driving.
// Every second tick (the first after reset included) also runs the outer
// heading loop and the forward speed ramp before the wheel loops.
// Configuration writes use the cfg channel (index, data); cfg_ready is always
// high, and writes are meant to land while no tick is in flight.
// Sequence: on an outer-loop tick the sequencer first steps through the angle,
// heading error, heading integral and target states; every tick then runs the
// wheel states for the left and then the right wheel. in_ready returns in the
// cycle after the result is loaded; no tick is taken while one is in flight.
// The single 34x18 multiplier takes every product of a tick in turn.
// Reset: all loop state clears to zero and the registers take their default
// gains. A stalled receiver holds the result in the output register; the block
// still takes the next tick and waits before loading its result.
`timescale 1ns / 1ps
`default_nettype none

module cascaded_heading_wheel_pi_control_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [chwpi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [chwpi_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [15:0]                   count_left,
	input  logic signed [15:0]                   count_right,
	input  logic signed [15:0]                   gyro_rate,
	input  logic                                 drive_enable,
	input  logic                                 restart,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [15:0]                   drive_left,
	output logic signed [15:0]                   drive_right,
	output logic                                 driving
);

	localparam int PW = chwpi_pkg::PROD_W;

	// Configuration registers
	logic [15:0] wkp_q, wki_q, hkp_q, hki_q, ramp_inc_q, ramp_limit_q;
	logic [30:0] travel_thr_q;
	logic signed [15:0] gyro_bias_q;

	// Loop state
	chwpi_pkg::state_t state_q, state_d;
	logic               phase_q;
	logic               widx_q;
	logic signed [31:0] travel_l_q, travel_r_q;
	logic signed [31:0] angle_q;
	logic signed [23:0] hsum_q;
	logic signed [23:0] wsum_q [2];
	logic [15:0]        fspeed_q;
	logic signed [23:0] tgt_q [2];
	logic signed [15:0] drv_q [2];

	// Captured tick and datapath registers
	logic signed [15:0] cnt_l_q, cnt_r_q, gyro_q;
	logic               en_q;
	logic signed [24:0] err_q;
	logic signed [PW-1:0] prod_q, acc_q;

	// Output register
	logic               out_valid_q;
	logic signed [15:0] out_l_q, out_r_q;
	logic               out_drv_q;

	logic in_fire, out_load;
	logic signed [chwpi_pkg::MUL_A_W-1:0] mul_a;
	logic signed [chwpi_pkg::MUL_B_W-1:0] mul_b;
	logic signed [PW-1:0] prod_c;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [33:0] hi, lo;
		hi = 34'sd2147483647;
		lo = -34'sd2147483648;
		if (v > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [23:0] clamp_sum(input logic signed [27:0] v);
		logic signed [27:0] lim;
		lim = 28'(chwpi_pkg::SUM_CLAMP);
		if (v > lim) begin
			return lim[23:0];
		end else if (v < -lim) begin
			return -lim[23:0];
		end
		return v[23:0];
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [28:0] v);
		if (v > 29'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (v < -29'sd8388608) begin
			return 24'sh800000;
		end
		return v[23:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
		if (v > 36'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -36'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// Arithmetic around the shared multiplier
	logic signed [16:0] omega;
	logic signed [32:0] herr;
	logic signed [33:0] angle_sum;
	logic signed [32:0] tsum, half;
	logic [16:0]        fs_add;
	logic [15:0]        fs_next;
	logic signed [27:0] hsum_sum;
	logic signed [PW-1:0] csum;
	logic signed [27:0] corr;
	logic signed [28:0] tgt0_c, tgt1_c;
	logic signed [15:0] cnt_sel;
	logic signed [23:0] tgt_sel;
	logic signed [24:0] err_c;
	logic signed [27:0] wsum_sum;
	logic signed [PW-1:0] cmd, cmd_rnd;

	always_comb begin
		omega     = 17'(gyro_q) - 17'(gyro_bias_q);
		herr      = 33'sd0 - 33'(angle_q);
		angle_sum = 34'(angle_q) + $signed(prod_q[33:0]);

		// Half travel, truncated toward zero
		tsum = 33'(travel_l_q) + 33'(travel_r_q);
		half = (tsum + $signed({32'd0, tsum[32]})) >>> 1;
		fs_add = {1'b0, fspeed_q} + {1'b0, ramp_inc_q};
		if (half < $signed({2'b00, travel_thr_q})) begin
			if (fspeed_q < ramp_limit_q) begin
				fs_next = fs_add[16] ? 16'hFFFF : fs_add[15:0];
			end else begin
				fs_next = ramp_limit_q;
			end
		end else begin
			fs_next = '0;
		end

		hsum_sum = 28'(hsum_q) + 28'($signed(prod_q[41:16]));
		csum     = acc_q + prod_q;
		corr     = $signed(csum[51:24]);
		tgt0_c   = $signed({13'd0, fspeed_q}) - 29'(corr);
		tgt1_c   = $signed({13'd0, fspeed_q}) + 29'(corr);

		cnt_sel  = widx_q ? cnt_r_q : cnt_l_q;
		tgt_sel  = tgt_q[widx_q];
		err_c    = 25'(tgt_sel) - $signed({cnt_sel, 8'd0});
		wsum_sum = 28'(wsum_q[widx_q]) + 28'($signed(prod_q[32:8]));

		// Command in Q16, truncated toward zero
		cmd     = acc_q + (prod_q >>> 16);
		cmd_rnd = cmd + (cmd[PW-1] ? PW'(65535) : PW'(0));
	end

	// Multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			chwpi_pkg::ST_ANG_MUL: begin
				mul_a = 34'(omega);
				mul_b = chwpi_pkg::DT_Q16;
			end
			chwpi_pkg::ST_HERR_MUL: begin
				mul_a = 34'(herr);
				mul_b = chwpi_pkg::DT_Q16;
			end
			chwpi_pkg::ST_HSUM: begin
				mul_a = 34'(herr);
				mul_b = $signed({2'b00, hkp_q});
			end
			chwpi_pkg::ST_HKI: begin
				mul_a = 34'(hsum_q);
				mul_b = $signed({2'b00, hki_q});
			end
			chwpi_pkg::ST_WI_MUL: begin
				mul_a = 34'(err_q);
				mul_b = chwpi_pkg::DT1_Q16;
			end
			chwpi_pkg::ST_WSUM: begin
				mul_a = 34'(err_q);
				mul_b = $signed({2'b00, wkp_q});
			end
			chwpi_pkg::ST_WKI: begin
				mul_a = 34'(wsum_q[widx_q]);
				mul_b = $signed({2'b00, wki_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_c = mul_a * mul_b;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chwpi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			chwpi_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = phase_q ? chwpi_pkg::ST_WERR : chwpi_pkg::ST_ANG_MUL;
				end
			end
			chwpi_pkg::ST_ANG_MUL:  state_d = chwpi_pkg::ST_ANG_ADD;
			chwpi_pkg::ST_ANG_ADD:  state_d = chwpi_pkg::ST_HERR_MUL;
			chwpi_pkg::ST_HERR_MUL: state_d = chwpi_pkg::ST_HSUM;
			chwpi_pkg::ST_HSUM:     state_d = chwpi_pkg::ST_HKI;
			chwpi_pkg::ST_HKI:      state_d = chwpi_pkg::ST_TGT;
			chwpi_pkg::ST_TGT:      state_d = chwpi_pkg::ST_WERR;
			chwpi_pkg::ST_WERR:     state_d = chwpi_pkg::ST_WI_MUL;
			chwpi_pkg::ST_WI_MUL:   state_d = chwpi_pkg::ST_WSUM;
			chwpi_pkg::ST_WSUM:     state_d = chwpi_pkg::ST_WKI;
			chwpi_pkg::ST_WKI:      state_d = chwpi_pkg::ST_WCMD;
			chwpi_pkg::ST_WCMD: begin
				state_d = widx_q ? chwpi_pkg::ST_DONE : chwpi_pkg::ST_WERR;
			end
			chwpi_pkg::ST_DONE: begin
				// Hold until the output register is free
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = chwpi_pkg::ST_IDLE;
				end
			end
			default: state_d = chwpi_pkg::ST_IDLE;
		endcase
	end

	assign in_fire = in_valid && in_ready;

	// Configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wkp_q        <= chwpi_pkg::WHEEL_KP_RST;
			wki_q        <= chwpi_pkg::WHEEL_KI_RST;
			hkp_q        <= chwpi_pkg::HEAD_KP_RST;
			hki_q        <= chwpi_pkg::HEAD_KI_RST;
			ramp_inc_q   <= chwpi_pkg::RAMP_INC_RST;
			ramp_limit_q <= chwpi_pkg::RAMP_LIMIT_RST;
			travel_thr_q <= '0;
			gyro_bias_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				chwpi_pkg::REG_WHEEL_KP:   wkp_q        <= cfg_data[15:0];
				chwpi_pkg::REG_WHEEL_KI:   wki_q        <= cfg_data[15:0];
				chwpi_pkg::REG_HEAD_KP:    hkp_q        <= cfg_data[15:0];
				chwpi_pkg::REG_HEAD_KI:    hki_q        <= cfg_data[15:0];
				chwpi_pkg::REG_RAMP_INC:   ramp_inc_q   <= cfg_data[15:0];
				chwpi_pkg::REG_RAMP_LIMIT: ramp_limit_q <= cfg_data[15:0];
				chwpi_pkg::REG_TRAVEL_THR: travel_thr_q <= cfg_data;
				chwpi_pkg::REG_GYRO_BIAS:  gyro_bias_q  <= $signed(cfg_data[15:0]);
				default: ;
			endcase
		end
	end

	// Datapath registers without reset
	always_ff @(posedge clk) begin
		prod_q <= prod_c;
		if (in_fire) begin
			cnt_l_q <= count_left;
			cnt_r_q <= count_right;
			gyro_q  <= gyro_rate;
			en_q    <= drive_enable;
		end
		if (state_q == chwpi_pkg::ST_HKI || state_q == chwpi_pkg::ST_WKI) begin
			acc_q <= prod_q;
		end
		if (state_q == chwpi_pkg::ST_WERR) begin
			err_q <= err_c;
		end
	end

	// Controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= 1'b0;
			widx_q     <= 1'b0;
			travel_l_q <= '0;
			travel_r_q <= '0;
			angle_q    <= '0;
			hsum_q     <= '0;
			wsum_q[0]  <= '0;
			wsum_q[1]  <= '0;
			fspeed_q   <= '0;
			tgt_q[0]   <= '0;
			tgt_q[1]   <= '0;
			drv_q[0]   <= '0;
			drv_q[1]   <= '0;
		end else begin
			case (state_q)
				chwpi_pkg::ST_IDLE: begin
					if (in_fire) begin
						phase_q <= ~phase_q;
						widx_q  <= 1'b0;
						if (restart) begin
							travel_l_q <= '0;
							travel_r_q <= '0;
							angle_q    <= '0;
						end
					end
				end
				chwpi_pkg::ST_ANG_ADD: begin
					angle_q  <= sat32(angle_sum);
					fspeed_q <= fs_next;
				end
				chwpi_pkg::ST_HSUM: begin
					hsum_q <= clamp_sum(hsum_sum);
				end
				chwpi_pkg::ST_TGT: begin
					tgt_q[0] <= sat24(tgt0_c);
					tgt_q[1] <= sat24(tgt1_c);
				end
				chwpi_pkg::ST_WERR: begin
					// Travels take this tick's counts after the outer loop
					if (!widx_q) begin
						travel_l_q <= sat32(34'(travel_l_q) + 34'(cnt_l_q));
						travel_r_q <= sat32(34'(travel_r_q) + 34'(cnt_r_q));
					end
				end
				chwpi_pkg::ST_WSUM: begin
					wsum_q[widx_q] <= clamp_sum(wsum_sum);
				end
				chwpi_pkg::ST_WCMD: begin
					drv_q[widx_q] <= sat16($signed(cmd_rnd[PW-1:16]));
					widx_q        <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_l_q     <= '0;
			out_r_q     <= '0;
			out_drv_q   <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			out_l_q     <= en_q ? drv_q[0] : 16'sd0;
			out_r_q     <= en_q ? drv_q[1] : 16'sd0;
			out_drv_q   <= en_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_left  = out_l_q;
	assign drive_right = out_r_q;
	assign driving     = out_drv_q;

endmodule

`default_nettype wire

@@ hdl/chwpi_checker.sv @@
// Port-level checker for the cascaded heading and wheel PI controller.
`timescale 1ns / 1ps
`default_nettype none

module chwpi_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [15:0]               drive_left,
	input logic signed [15:0]               drive_right,
	input logic                             driving
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(drive_left) && $stable(drive_right)
			&& $stable(driving))
		else $error("stalled result changed");

	// Free motors carry zero commands
	a_free_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !driving |-> drive_left == 16'sd0 && drive_right == 16'sd0)
		else $error("nonzero command while motors free");

	// One tick at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while busy");

	// A result cannot appear in the cycle right after a tick is taken
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind cascaded_heading_wheel_pi_control_top chwpi_checker u_chwpi_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the cascaded heading and wheel PI controller.
`timescale 1ns / 1ps

module tb;
	import chwpi_pkg::*;

	localparam int NUM_REGS = 8;
	localparam int NUM_SETTINGS = 4;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 30;
	localparam longint I32_MAX = 64'sd2147483647;
	localparam longint I32_MIN = -64'sd2147483648;
	localparam longint TGT_HI = 64'sd8388607;
	localparam longint TGT_LO = -64'sd8388608;
	localparam longint CLAMP_50 = SUM_CLAMP;

	typedef struct packed {
		logic signed [15:0] cnt_l;
		logic signed [15:0] cnt_r;
		logic signed [15:0] gyro;
		logic               enable;
		logic               restart;
	} tick_t;

	typedef struct packed {
		logic signed [15:0] left_cmd;
		logic signed [15:0] right_cmd;
		logic               active;
	} motor_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	tick_t in_tick = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] drive_left;
	logic signed [15:0] drive_right;
	logic driving;

	// Hand-written expectation travelling with the transaction
	logic lit_valid = 1'b0;
	motor_cmd_t lit_cmd = '0;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic hold_toggle = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;
	int cur_bias = 0;

	motor_cmd_t cmd_expect_q[$];
	int tick_count = 0;
	int cmd_count = 0;
	int cmd_errors = 0;

	// Controller state mirror
	longint k_whl_p = WHEEL_KP_RST;
	longint k_whl_i = WHEEL_KI_RST;
	longint k_hdg_p = HEAD_KP_RST;
	longint k_hdg_i = HEAD_KI_RST;
	longint ramp_step = RAMP_INC_RST;
	longint ramp_ceiling = RAMP_LIMIT_RST;
	longint stop_distance = 0;
	longint rate_bias = 0;
	longint trav_left = 0;
	longint trav_right = 0;
	longint ang_acc = 0;
	longint ang_err_sum = 0;
	longint fwd_speed = 0;
	longint whl_tgt[2] = '{0, 0};
	longint whl_err_sum[2] = '{0, 0};
	bit outer_idle = 1'b0;

	logic [30:0] reg_sets [NUM_SETTINGS][NUM_REGS];
	int set_tx_pct[NUM_SETTINGS] = '{33, 56, 0, 0};
	int set_rx_pct[NUM_SETTINGS] = '{56, 33, 0, 0};
	int set_items[NUM_SETTINGS] = '{250, 620, 60, 200};
	int spin_items = 520;

	tick_t dir_ticks[$];
	bit dir_has_lit[$];
	motor_cmd_t dir_lit[$];

	cascaded_heading_wheel_pi_control_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.count_left(in_tick.cnt_l),
		.count_right(in_tick.cnt_r),
		.gyro_rate(in_tick.gyro),
		.drive_enable(in_tick.enable),
		.restart(in_tick.restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_left(drive_left),
		.drive_right(drive_right),
		.driving(driving)
	);

	always #5 clk = ~clk;

	function automatic longint sat(input longint x, input longint lo, input longint hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	function automatic longint wheel_pi(input int w, input longint cnt);
		longint err, cmd;
		err = whl_tgt[w] - cnt * 256;
		whl_err_sum[w] = sat(whl_err_sum[w] + ((err * longint'(DT1_Q16)) >>> 8),
			-CLAMP_50, CLAMP_50);
		cmd = k_whl_p * err + ((k_whl_i * whl_err_sum[w]) >>> 16);
		// truncate toward zero, not floor
		cmd = (cmd < 0) ? -((-cmd) >>> 16) : (cmd >>> 16);
		return sat(cmd, -64'sd32768, 64'sd32767);
	endfunction

	function automatic motor_cmd_t predict_tick(input tick_t t);
		longint cl, cr, herr, corr, half, dl, dr;
		motor_cmd_t r;
		cl = $signed(t.cnt_l);
		cr = $signed(t.cnt_r);
		if (t.restart) begin
			trav_left = 0;
			trav_right = 0;
			ang_acc = 0;
		end
		if (!outer_idle) begin
			ang_acc = sat(ang_acc + (longint'($signed(t.gyro)) - rate_bias) *
				longint'(DT_Q16), I32_MIN, I32_MAX);
			// distance check uses travel before this tick's counts
			half = (trav_left + trav_right) / 2;
			if (half < stop_distance) begin
				if (fwd_speed < ramp_ceiling)
					fwd_speed = (fwd_speed + ramp_step > 65535) ? 65535 : fwd_speed + ramp_step;
				else
					fwd_speed = ramp_ceiling;
			end else
				fwd_speed = 0;
			herr = -ang_acc;
			ang_err_sum = sat(ang_err_sum + ((herr * longint'(DT_Q16)) >>> 16),
				-CLAMP_50, CLAMP_50);
			corr = (k_hdg_p * herr + k_hdg_i * ang_err_sum) >>> 24;
			whl_tgt[0] = sat(fwd_speed - corr, TGT_LO, TGT_HI);
			whl_tgt[1] = sat(fwd_speed + corr, TGT_LO, TGT_HI);
		end
		outer_idle = !outer_idle;
		trav_left = sat(trav_left + cl, I32_MIN, I32_MAX);
		trav_right = sat(trav_right + cr, I32_MIN, I32_MAX);
		dl = wheel_pi(0, cl);
		dr = wheel_pi(1, cr);
		r.left_cmd = t.enable ? dl[15:0] : 16'sd0;
		r.right_cmd = t.enable ? dr[15:0] : 16'sd0;
		r.active = t.enable;
		return r;
	endfunction

	// Model update and result checking
	always @(posedge clk) begin
		motor_cmd_t pred, want;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WHEEL_KP: k_whl_p = cfg_data[15:0];
				REG_WHEEL_KI: k_whl_i = cfg_data[15:0];
				REG_HEAD_KP: k_hdg_p = cfg_data[15:0];
				REG_HEAD_KI: k_hdg_i = cfg_data[15:0];
				REG_RAMP_INC: ramp_step = cfg_data[15:0];
				REG_RAMP_LIMIT: ramp_ceiling = cfg_data[15:0];
				REG_TRAVEL_THR: stop_distance = cfg_data;
				REG_GYRO_BIAS: rate_bias = $signed(cfg_data[15:0]);
				default: ;
			endcase
		end
		if (in_valid && in_ready) begin
			pred = predict_tick(in_tick);
			cmd_expect_q.push_back(lit_valid ? lit_cmd : pred);
			tick_count++;
		end
		if (out_valid && out_ready) begin
			if (cmd_expect_q.size() == 0) begin
				$error("unexpected output transaction: drive_left %0d drive_right %0d driving %0b",
					drive_left, drive_right, driving);
				cmd_errors++;
			end else begin
				want = cmd_expect_q.pop_front();
				cmd_count++;
				if (want.left_cmd !== drive_left) begin
					$error("drive_left expected %0d actual %0d", want.left_cmd, drive_left);
					cmd_errors++;
				end
				if (want.right_cmd !== drive_right) begin
					$error("drive_right expected %0d actual %0d", want.right_cmd, drive_right);
					cmd_errors++;
				end
				if (want.active !== driving) begin
					$error("driving expected %0b actual %0b", want.active, driving);
					cmd_errors++;
				end
			end
		end
	end

	// Output side: random stalls plus an occasional long hold-off
	always @(posedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	task automatic add_row(input int cl, input int cr, input int gz, input bit en, input bit rs,
		input bit has_lit, input int el, input int er, input bit ed);
		tick_t t;
		motor_cmd_t c;
		t.cnt_l = 16'(cl);
		t.cnt_r = 16'(cr);
		t.gyro = 16'(gz);
		t.enable = en;
		t.restart = rs;
		c.left_cmd = 16'(el);
		c.right_cmd = 16'(er);
		c.active = ed;
		dir_ticks.push_back(t);
		dir_has_lit.push_back(has_lit);
		dir_lit.push_back(c);
	endtask

	task automatic drive_tick(input tick_t t, input bit has_lit, input motor_cmd_t lit);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_tick <= t;
		lit_valid <= has_lit;
		lit_cmd <= lit;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (cmd_expect_q.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic program_setting(input int s);
		for (int r = 0; r < NUM_REGS; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_W'(r);
			// junk above bit 15 must be dropped by the 16-bit registers
			if (CFG_IDX_W'(r) == REG_TRAVEL_THR)
				cfg_data <= reg_sets[s][r];
			else
				cfg_data <= {15'($urandom), reg_sets[s][r][15:0]};
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic tick_t random_tick(input bit spin);
		tick_t t;
		if (!spin && $urandom_range(99) < 15) begin
			t.cnt_l = 16'($urandom);
			t.cnt_r = 16'($urandom);
			t.gyro = 16'($urandom);
			t.enable = 1'($urandom);
			t.restart = 1'($urandom);
		end else begin
			t.cnt_l = 16'(int'($urandom_range(80)) - 20);
			t.cnt_r = 16'(int'($urandom_range(80)) - 20);
			t.gyro = spin ? 16'sd32767 : 16'(cur_bias + int'($urandom_range(400)) - 200);
			t.enable = ($urandom_range(9) != 0);
			t.restart = spin ? 1'b0 : ($urandom_range(49) == 0);
		end
		return t;
	endfunction

	initial begin
		motor_cmd_t no_cmd;
		no_cmd = '0;
		reg_sets[0] = '{31'd3000, 31'd20000, 31'd4063, 31'd66, 31'd13, 31'd15360,
			31'd3000, 31'd150};
		reg_sets[1] = '{31'd65535, 31'd65535, 31'd65535, 31'd65535, 31'd40000, 31'd65535,
			31'h7FFFFFFF, 31'h8000};
		reg_sets[2] = '{31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'h7FFF};
		reg_sets[3] = '{31'd12000, 31'd40000, 31'd30000, 31'd5000, 31'd30, 31'd100,
			31'd800, 31'hFFD8};

		// Default gains, zero travel threshold: targets stay at zero while gyro is zero
		add_row(0, 0, 0, 1, 0, 1, 0, 0, 1);
		add_row(32767, -32768, 0, 1, 0, 1, -32768, 32767, 1);
		add_row(-32768, 32767, 0, 0, 0, 1, 0, 0, 0);
		add_row(-32768, 32767, 0, 1, 0, 1, 32767, -32768, 1);
		add_row(0, 0, 32767, 1, 0, 0, 0, 0, 0);
		add_row(0, 0, 32767, 1, 0, 0, 0, 0, 0);
		add_row(0, 0, -32768, 1, 0, 0, 0, 0, 0);
		add_row(0, 0, -32768, 1, 1, 0, 0, 0, 0);
		add_row(1, -1, -1, 0, 1, 1, 0, 0, 0);
		add_row(21845, -21846, 21845, 1, 0, 0, 0, 0, 0);
		add_row(-21846, 21845, -21846, 1, 0, 0, 0, 0, 0);
		add_row(-1, -1, -1, 1, 1, 0, 0, 0, 0);
		add_row(7, -9, 3, 0, 0, 1, 0, 0, 0);
		add_row(40, 40, 0, 1, 0, 0, 0, 0, 0);
		add_row(-40, -40, 0, 1, 0, 0, 0, 0, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < dir_ticks.size(); i++)
			drive_tick(dir_ticks[i], dir_has_lit[i], dir_lit[i]);

		for (int s = 0; s < NUM_SETTINGS; s++) begin
			wait_drained();
			program_setting(s);
			tx_idle_pct = set_tx_pct[s];
			rx_idle_pct <= set_rx_pct[s];
			cur_bias = $signed(reg_sets[s][REG_GYRO_BIAS][15:0]);
			for (int n = 0; n < set_items[s]; n++) begin
				// stall the output long enough to back up the input
				if (s == 0 && n == 100)
					hold_toggle <= ~hold_toggle;
				if (s == 0 && n == 200)
					wait_drained();
				// full-scale spin to drive the heading angle and targets into saturation
				drive_tick(random_tick(s == 1 && n < spin_items), 1'b0, no_cmd);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Checked %0d motor commands from %0d control ticks under %0d register settings",
			cmd_count, tick_count, NUM_SETTINGS + 1);
		$display("(ramp and cutoff, heading and integral clamps, restart, disable, backpressure).");
		if (cmd_errors == 0)
			$display("cascaded_heading_wheel_pi_control_top test passed");
		else
			$display("cascaded_heading_wheel_pi_control_top test failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("cascaded_heading_wheel_pi_control_top test failed");
		$finish;
	end

endmodule
